### hdl/twn_pkg.sv
package twn_pkg;

  localparam int Rounds = 36;
  localparam int RndW   = 6;

  // nibble 0 is the most significant nibble
  typedef logic [0:15][3:0] blk_t;
  typedef logic [0:31][3:0] key_t;
  typedef logic [0:7][3:0]  rk_t;

  typedef struct packed {
    logic valid;
    logic action;
  } ctl_t;

  localparam logic [1:0] REG_KEY_HIGH = 2'd0;
  localparam logic [1:0] REG_KEY_LOW  = 2'd1;
  localparam logic [1:0] REG_KEY_LONG = 2'd2;

  localparam logic [3:0] FWD_PI [16] = '{4'd5, 4'd0, 4'd1, 4'd4, 4'd7, 4'd12, 4'd3, 4'd8,
                                         4'd13, 4'd6, 4'd9, 4'd2, 4'd15, 4'd10, 4'd11, 4'd14};
  localparam logic [3:0] INV_PI [16] = '{4'd1, 4'd2, 4'd11, 4'd6, 4'd3, 4'd0, 4'd9, 4'd4,
                                         4'd7, 4'd10, 4'd13, 4'd14, 4'd5, 4'd8, 4'd15, 4'd12};
  localparam logic [4:0] PICK80  [8] = '{5'd1, 5'd3, 5'd4, 5'd6, 5'd13, 5'd14, 5'd15, 5'd16};
  localparam logic [4:0] PICK128 [8] = '{5'd2, 5'd3, 5'd12, 5'd15, 5'd17, 5'd18, 5'd28, 5'd31};

  function automatic logic [3:0] sbox(logic [3:0] a);
    logic [3:0] s;
    case (a)
      4'h0: s = 4'hc;
      4'h1: s = 4'h0;
      4'h2: s = 4'hf;
      4'h3: s = 4'ha;
      4'h4: s = 4'h2;
      4'h5: s = 4'hb;
      4'h6: s = 4'h9;
      4'h7: s = 4'h5;
      4'h8: s = 4'h8;
      4'h9: s = 4'h3;
      4'ha: s = 4'hd;
      4'hb: s = 4'h7;
      4'hc: s = 4'h1;
      4'hd: s = 4'he;
      4'he: s = 4'h6;
      default: s = 4'h4;
    endcase
    return s;
  endfunction

  function automatic logic [5:0] con_of(logic [RndW-1:0] r);
    logic [5:0] c;
    case (r)
      6'd0:  c = 6'h01;
      6'd1:  c = 6'h02;
      6'd2:  c = 6'h04;
      6'd3:  c = 6'h08;
      6'd4:  c = 6'h10;
      6'd5:  c = 6'h20;
      6'd6:  c = 6'h03;
      6'd7:  c = 6'h06;
      6'd8:  c = 6'h0c;
      6'd9:  c = 6'h18;
      6'd10: c = 6'h30;
      6'd11: c = 6'h23;
      6'd12: c = 6'h05;
      6'd13: c = 6'h0a;
      6'd14: c = 6'h14;
      6'd15: c = 6'h28;
      6'd16: c = 6'h13;
      6'd17: c = 6'h26;
      6'd18: c = 6'h0f;
      6'd19: c = 6'h1e;
      6'd20: c = 6'h3c;
      6'd21: c = 6'h3b;
      6'd22: c = 6'h35;
      6'd23: c = 6'h29;
      6'd24: c = 6'h11;
      6'd25: c = 6'h22;
      6'd26: c = 6'h07;
      6'd27: c = 6'h0e;
      6'd28: c = 6'h1c;
      6'd29: c = 6'h38;
      6'd30: c = 6'h33;
      6'd31: c = 6'h25;
      6'd32: c = 6'h09;
      6'd33: c = 6'h12;
      6'd34: c = 6'h24;
      default: c = 6'h00;
    endcase
    return c;
  endfunction

  function automatic rk_t take_rk(key_t k, logic wide);
    rk_t rk;
    for (int i = 0; i < 8; i++) begin
      rk[i] = wide ? k[PICK128[i]] : k[PICK80[i]];
    end
    return rk;
  endfunction

  function automatic key_t ks_step(key_t k, logic wide, logic [5:0] c);
    key_t m;
    key_t y;
    m = k;
    m[1] = m[1] ^ sbox(m[0]);
    m[4] = m[4] ^ sbox(m[16]);
    if (wide) begin
      m[23] = m[23] ^ sbox(m[30]);
    end
    m[7]  = m[7] ^ {1'b0, c[5:3]};
    m[19] = m[19] ^ {1'b0, c[2:0]};
    y = m;
    if (wide) begin
      for (int i = 0; i < 28; i++) begin
        y[i] = m[i+4];
      end
      y[28] = m[1];
      y[29] = m[2];
      y[30] = m[3];
      y[31] = m[0];
    end else begin
      for (int i = 0; i < 16; i++) begin
        y[i] = m[i+4];
      end
      y[16] = m[1];
      y[17] = m[2];
      y[18] = m[3];
      y[19] = m[0];
    end
    return y;
  endfunction

  function automatic blk_t mix(blk_t x, rk_t rk);
    blk_t y;
    y = x;
    for (int j = 0; j < 8; j++) begin
      y[2*j+1] = x[2*j+1] ^ sbox(x[2*j] ^ rk[j]);
    end
    return y;
  endfunction

  function automatic blk_t shuffle(blk_t x, logic inverse);
    blk_t y;
    y = x;
    for (int j = 0; j < 16; j++) begin
      if (inverse) begin
        y[INV_PI[j]] = x[j];
      end else begin
        y[FWD_PI[j]] = x[j];
      end
    end
    return y;
  endfunction

endpackage

### hdl/twn_keysched.sv
module twn_keysched (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [63:0]       cfg_data,
  output logic              key_ready,
  output twn_pkg::rk_t      rk [twn_pkg::Rounds]
);
  import twn_pkg::*;

  logic [63:0]     key_high;
  logic [63:0]     key_low;
  logic            key_long;
  logic            pending;
  logic            run;
  logic [RndW-1:0] cnt;
  key_t            k;

  assign key_ready = !pending && !run;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_high <= '0;
      key_low  <= '0;
      key_long <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_KEY_HIGH: key_high <= cfg_data;
        REG_KEY_LOW:  key_low  <= cfg_data;
        REG_KEY_LONG: key_long <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // one schedule step per cycle; a write restarts the pass
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= 1'b1;
      run     <= 1'b0;
      cnt     <= '0;
    end else begin
      if (pending) begin
        run <= 1'b1;
        cnt <= '0;
      end else if (run) begin
        if (cnt == RndW'(Rounds - 1)) begin
          run <= 1'b0;
        end else begin
          cnt <= cnt + 1'b1;
        end
      end
      pending <= cfg_we;
    end
  end

  always_ff @(posedge clk) begin
    if (pending) begin
      k <= key_t'({key_high, key_low});
    end else if (run) begin
      rk[cnt] <= take_rk(k, key_long);
      k       <= ks_step(k, key_long, con_of(cnt));
    end
  end

endmodule

### hdl/twn_cell.sv
module twn_cell (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          permute,
  input  twn_pkg::rk_t  rk_enc,
  input  twn_pkg::rk_t  rk_dec,
  input  twn_pkg::ctl_t ctl_in,
  input  twn_pkg::blk_t st_in,
  output twn_pkg::ctl_t ctl_out,
  output twn_pkg::blk_t st_out
);
  import twn_pkg::*;

  blk_t mixed;
  blk_t st_next;

  assign mixed   = mix(st_in, ctl_in.action ? rk_dec : rk_enc);
  assign st_next = permute ? shuffle(mixed, ctl_in.action) : mixed;

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out <= '0;
    end else if (en) begin
      ctl_out <= ctl_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st_out <= st_next;
    end
  end

endmodule

### hdl/lightweight_block_cipher_64.sv
// TWINE-64 encrypt/decrypt engine, one 64-bit block per transaction. The data path is a
// chain of 36 round cells plus an output register; a new block can be accepted every cycle
// while in_ready is high. After reset and after every configuration write, the key
// schedule unit computes the 36 round keys (one schedule step per cycle); in_ready stays
// low during that pass. Write the key registers only while no blocks are in flight. A
// one-entry skid register behind the output takes the block leaving the chain when
// out_ready is low, so the chain stalls only once that skid register is full.
module lightweight_block_cipher_64 (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        action,
  input  logic [63:0] block_in,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] block_out
);
  import twn_pkg::*;

  logic        key_ready;
  rk_t         rk [Rounds];
  ctl_t        ctl [Rounds+1];
  blk_t        st [Rounds+1];
  logic        en;
  logic        push;
  logic        take;
  logic        ov;
  logic        sv;
  logic [63:0] odata;
  logic [63:0] sdata;

  twn_keysched u_keysched (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .key_ready (key_ready),
    .rk        (rk)
  );

  assign en       = !sv;
  assign in_ready = en && key_ready;

  assign ctl[0].valid  = in_valid && in_ready;
  assign ctl[0].action = action;
  assign st[0]         = blk_t'(block_in);

  for (genvar r = 0; r < Rounds; r++) begin : g_round
    twn_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .en      (en),
      .permute (r != Rounds - 1),
      .rk_enc  (rk[r]),
      .rk_dec  (rk[Rounds-1-r]),
      .ctl_in  (ctl[r]),
      .st_in   (st[r]),
      .ctl_out (ctl[r+1]),
      .st_out  (st[r+1])
    );
  end

  assign push = en && ctl[Rounds].valid;
  assign take = ov && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      ov <= 1'b0;
      sv <= 1'b0;
    end else if (sv) begin
      if (take) begin
        sv <= 1'b0;
      end
    end else if (push) begin
      if (ov && !out_ready) begin
        sv <= 1'b1;
      end else begin
        ov <= 1'b1;
      end
    end else if (take) begin
      ov <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (sv) begin
      if (take) begin
        odata <= sdata;
      end
    end else if (push) begin
      if (ov && !out_ready) begin
        sdata <= 64'(st[Rounds]);
      end else begin
        odata <= 64'(st[Rounds]);
      end
    end
  end

  assign out_valid = ov;
  assign block_out = odata;

`ifndef ASSERT_OFF
  a_skid_needs_out: assert property (@(posedge clk) disable iff (rst) sv |-> ov)
    else $error("skid register full while output register empty");
  a_skid_fill: assert property (@(posedge clk) disable iff (rst)
    $rose(sv) |-> $past(ov && !out_ready))
    else $error("skid register filled without a stalled output");
  a_skid_drain: assert property (@(posedge clk) disable iff (rst)
    sv && out_ready |=> ov && !sv)
    else $error("skid register did not drain into output register");
  a_out_drop: assert property (@(posedge clk) disable iff (rst)
    take && !sv && !push |=> !ov)
    else $error("output stayed valid after transaction with nothing behind it");
`endif

endmodule
